### hdl/vr3_pkg.sv
package vr3_pkg;

  // Width of one operand slice in the pipelined multipliers
  localparam int MUL_CHUNK = 32;

  // Reflection modes
  localparam logic [1:0] MODE_VECTOR = 2'd0;
  localparam logic [1:0] MODE_AXIS   = 2'd1;
  localparam logic [1:0] MODE_PLANE  = 2'd2;

endpackage

### hdl/vr3_mul.sv
module vr3_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic [AW+BW-1:0]  p
);

  localparam int CW = vr3_pkg::MUL_CHUNK;
  localparam int NA = (AW + CW - 1) / CW;
  localparam int NB = (BW + CW - 1) / CW;
  localparam int AP = NA * CW;
  localparam int BP = NB * CW;
  localparam int SW = AP + BP;

  logic [AP-1:0]     a_pad;
  logic [BP-1:0]     b_pad;
  logic [2*CW-1:0]   pp [NA][NB];
  logic [SW-1:0]     sum;

  assign a_pad = AP'(a);
  assign b_pad = BP'(b);

  // Form slice products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
        end
      end
    end
  end

  // Add shifted slice products
  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp[i][j]) << ((i + j) * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum[AW+BW-1:0];
    end
  end

endmodule

### hdl/vr3_div.sv
module vr3_div #(
  parameter int NW = 97,
  parameter int DW = 64,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [NW-1:0] rem [QB+1];
  logic [DW-1:0] dv  [QB+1];
  logic [QB-1:0] qv  [QB+1];
  logic          up;

  // Restoring division, one quotient bit per stage, MSB first
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dv[0]  <= den;
      qv[0]  <= '0;
      for (int s = 0; s < QB; s++) begin
        if (rem[s] >= (NW'(dv[s]) << (QB - 1 - s))) begin
          rem[s+1] <= rem[s] - (NW'(dv[s]) << (QB - 1 - s));
          qv[s+1]  <= {qv[s][QB-2:0], 1'b1};
        end else begin
          rem[s+1] <= rem[s];
          qv[s+1]  <= {qv[s][QB-2:0], 1'b0};
        end
        dv[s+1] <= dv[s];
      end
    end
  end

  // Round half away from zero on the magnitude
  assign up = {rem[QB][DW-1:0], 1'b0} >= {1'b0, dv[QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= qv[QB] + QB'(up);
    end
  end

endmodule

### hdl/vector_reflection_3d.sv
// Reflects a 3D vector in signed fixed point (COORD_WIDTH bits, FRAC_BITS
// fraction bits) about a mirror vector (mode 0), a unit axis (mode 1) or in a
// plane given by its unit normal (mode 2); mode 3 passes the vector through.
// The block is a flat pipeline that takes one word per cycle while the output
// word is taken or empty; two rounds of pipelined multipliers and the exact
// rounding division by the squared mirror length, which resolves one quotient
// bit per stage, set its depth. When the result at the output is not taken, the
// whole pipeline holds and in_ready drops. A write of min_magnitude reaches the
// degeneracy checks through the threshold register and its squaring multiplier, which never stall.
module vector_reflection_3d #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [COORD_WIDTH-2:0]        min_magnitude,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic signed [COORD_WIDTH-1:0] vec_x,
  input  logic signed [COORD_WIDTH-1:0] vec_y,
  input  logic signed [COORD_WIDTH-1:0] vec_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  output logic                          degenerate,
  output logic                          saturated
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int TW   = 2 * W - 2;
  localparam int DW   = 2 * W;
  localparam int SDW  = 2 * W + 2;
  localparam int QMW  = 2 * W + 1;
  localparam int CSW  = 2 * W + 1;
  localparam int CCW  = 4 * W;
  localparam int SN   = 3 * W + 2;
  localparam int NW   = 3 * W + 1;
  localparam int QB   = W + 1;
  localparam int DL   = QB + 2;
  localparam int N1B  = (3 * W > W + 2 * F) ? 3 * W : W + 2 * F;
  localparam int N1W  = N1B + 2;
  localparam int R1W  = N1W - 2 * F;
  localparam int MXW  = R1W;
  localparam int T2B  = (CCW > TW + 2 * F) ? CCW : TW + 2 * F;
  localparam int TH2W = T2B + 1;
  localparam int T4B  = (6 * W > TW + 4 * F) ? 6 * W : TW + 4 * F;
  localparam int TH4W = T4B + 1;
  localparam int NST  = 8 + DL;

  typedef logic [W-1:0] coord_t;

  typedef struct packed {
    logic [1:0]       mode;
    coord_t [2:0]     v;
    coord_t [2:0]     m;
  } item_t;

  typedef struct packed {
    logic [1:0]       mode;
    coord_t [2:0]     v;
    logic [2:0]       msgn;
    logic             qneg;
    logic [DW-1:0]    den;
  } mid_t;

  typedef struct packed {
    logic [1:0]       mode;
    coord_t [2:0]     v;
    logic [2:0]       nneg;
    coord_t [2:0]     r1;
    logic             sat1;
    logic             deg0;
    logic             deg2a;
    logic             deg2b;
  } side_t;

  localparam coord_t CMAX = {1'b0, {(W-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(W-1){1'b0}}};

  function automatic coord_t mag_fn(input coord_t x);
    return x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // {saturated, value} for a signed magnitude clipped to W bits
  function automatic logic [W:0] clip_fn(input logic [MXW-1:0] mag, input logic neg);
    logic [MXW-1:0] lim;
    logic           sat;
    coord_t         val;
    lim = MXW'(1) << (W - 1);
    if (neg) begin
      sat = mag > lim;
      val = sat ? CMIN : W'(MXW'(0) - mag);
    end else begin
      sat = mag >= lim;
      val = sat ? CMAX : mag[W-1:0];
    end
    return {sat, val};
  endfunction

  logic               en;
  logic [NST-1:0]     vld;
  logic [W-2:0]       thr_len;
  logic [TW-1:0]      thr_sq;

  item_t              s0, a1, a2;
  coord_t             s0_mabs [3];
  coord_t             s0_vabs [3];
  logic [2*W-1:0]     pa_sq  [3];
  logic [2*W-1:0]     pa_dot [3];
  logic [2*W-1:0]     pa_cp  [3];
  logic [2*W-1:0]     pa_cn  [3];

  logic [DW-1:0]      den_n;
  logic signed [SDW-1:0] dot_n;
  logic signed [SDW-1:0] dot_abs;
  logic [DW-1:0]      cmag_n [3];
  mid_t               s1, b1, b2;
  logic [QMW-1:0]     s1_qmag;
  logic [DW-1:0]      s1_cmag [3];
  coord_t             s1_mabs [3];
  coord_t             s1_vabs [3];
  logic [3*W:0]       pb_qm [3];
  logic [3*W-1:0]     pb_vd [3];
  logic [4*W-1:0]     pb_cc [3];

  logic [NW-1:0]      n0mag_n [3];
  logic [2:0]         n0neg_n;
  coord_t             r1_n [3];
  logic [2:0]         r1sat_n;
  side_t              s2_side;
  logic [NW-1:0]      s2_n0mag [3];
  logic [DW-1:0]      s2_den;
  logic [CCW-1:0]     s2_cc;
  logic [6*W-1:0]     dencc;
  logic [QB-1:0]      quo [3];
  side_t              sd0, sd_fix;
  side_t              sd [1:DL];

  logic [W:0]         clp0 [3];
  logic [W:0]         clp2 [3];
  logic [W:0]         clpv [3];
  coord_t             fin_val [3];
  logic               fin_deg;
  logic               fin_sat;

  // Global advance: hold every pipeline stage while the output word waits
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // Threshold register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_len <= '0;
    end else if (cfg_wr_en) begin
      thr_len <= min_magnitude;
    end
  end

  vr3_mul #(.AW(W-1), .BW(W-1)) u_thr_sq (
    .clk(clk), .en(1'b1), .a(thr_len), .b(thr_len), .p(thr_sq)
  );

  // Capture input word
  always_ff @(posedge clk) begin
    if (en) begin
      s0.mode <= mode;
      s0.v[0] <= vec_x;
      s0.v[1] <= vec_y;
      s0.v[2] <= vec_z;
      s0.m[0] <= dir_x;
      s0.m[1] <= dir_y;
      s0.m[2] <= dir_z;
      a1      <= s0;
      a2      <= a1;
    end
  end

  // First products: squares, dot terms, cross terms
  for (genvar i = 0; i < 3; i++) begin : g_mula
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    logic signed [CSW-1:0] cpos, cneg, cdif;

    assign s0_mabs[i] = mag_fn(s0.m[i]);
    assign s0_vabs[i] = mag_fn(s0.v[i]);

    vr3_mul #(.AW(W), .BW(W)) u_sq (
      .clk(clk), .en(en), .a(s0_mabs[i]), .b(s0_mabs[i]), .p(pa_sq[i])
    );
    vr3_mul #(.AW(W), .BW(W)) u_dot (
      .clk(clk), .en(en), .a(s0_mabs[i]), .b(s0_vabs[i]), .p(pa_dot[i])
    );
    vr3_mul #(.AW(W), .BW(W)) u_cp (
      .clk(clk), .en(en), .a(s0_mabs[I1]), .b(s0_vabs[I2]), .p(pa_cp[i])
    );
    vr3_mul #(.AW(W), .BW(W)) u_cn (
      .clk(clk), .en(en), .a(s0_mabs[I2]), .b(s0_vabs[I1]), .p(pa_cn[i])
    );

    // Cross product component and its magnitude
    assign cpos = (a2.m[I1][W-1] ^ a2.v[I2][W-1]) ? -CSW'(pa_cp[i]) : CSW'(pa_cp[i]);
    assign cneg = (a2.m[I2][W-1] ^ a2.v[I1][W-1]) ? -CSW'(pa_cn[i]) : CSW'(pa_cn[i]);
    assign cdif = cpos - cneg;
    assign cmag_n[i] = cdif[CSW-1] ? DW'(-cdif) : DW'(cdif);
  end

  // Squared length and dot product
  always_comb begin
    den_n = DW'(pa_sq[0]) + DW'(pa_sq[1]) + DW'(pa_sq[2]);
    dot_n = '0;
    for (int i = 0; i < 3; i++) begin
      dot_n = dot_n + ((a2.m[i][W-1] ^ a2.v[i][W-1]) ? -SDW'(pa_dot[i]) : SDW'(pa_dot[i]));
    end
    dot_abs = dot_n[SDW-1] ? -dot_n : dot_n;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.mode <= a2.mode;
      s1.v    <= a2.v;
      s1.qneg <= dot_n[SDW-1];
      s1.den  <= den_n;
      s1_qmag <= {dot_abs[2*W-1:0], 1'b0};
      for (int i = 0; i < 3; i++) begin
        s1.msgn[i] <= a2.m[i][W-1];
        s1_cmag[i] <= cmag_n[i];
        s1_mabs[i] <= mag_fn(a2.m[i]);
      end
      b1 <= s1;
      b2 <= b1;
    end
  end

  // Second products, then numerators
  for (genvar i = 0; i < 3; i++) begin : g_mulb
    logic signed [SN-1:0]  tq, tv, n0;
    logic signed [N1W-1:0] t1, vext, n1;
    logic [N1W-1:0]        m1, rsum;
    logic [W:0]            c1;

    assign s1_vabs[i] = mag_fn(s1.v[i]);

    vr3_mul #(.AW(QMW), .BW(W)) u_qm (
      .clk(clk), .en(en), .a(s1_qmag), .b(s1_mabs[i]), .p(pb_qm[i])
    );
    vr3_mul #(.AW(W), .BW(DW)) u_vd (
      .clk(clk), .en(en), .a(s1_vabs[i]), .b(s1.den), .p(pb_vd[i])
    );
    vr3_mul #(.AW(DW), .BW(DW)) u_cc (
      .clk(clk), .en(en), .a(s1_cmag[i]), .b(s1_cmag[i]), .p(pb_cc[i])
    );

    // Mirror-vector numerator: 2(m.v)m - v|m|^2
    assign tq = (b2.qneg ^ b2.msgn[i]) ? -SN'(pb_qm[i]) : SN'(pb_qm[i]);
    assign tv = b2.v[i][W-1] ? -SN'(pb_vd[i]) : SN'(pb_vd[i]);
    assign n0 = tq - tv;
    assign n0neg_n[i] = n0[SN-1];
    assign n0mag_n[i] = n0[SN-1] ? NW'(-n0) : NW'(n0);

    // Unit-axis result: round the numerator by the fixed scale
    assign t1   = (b2.qneg ^ b2.msgn[i]) ? -N1W'(pb_qm[i]) : N1W'(pb_qm[i]);
    assign vext = {{(N1W-W){b2.v[i][W-1]}}, b2.v[i]};
    assign n1   = t1 - (vext << (2 * F));
    assign m1   = n1[N1W-1] ? N1W'(-n1) : N1W'(n1);
    assign rsum = m1 + (N1W'(1) << (2 * F - 1));
    assign c1   = clip_fn(MXW'(rsum[N1W-1:2*F]), n1[N1W-1]);
    assign r1_n[i]    = c1[W-1:0];
    assign r1sat_n[i] = c1[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_side.mode  <= b2.mode;
      s2_side.v     <= b2.v;
      s2_side.nneg  <= n0neg_n;
      s2_side.sat1  <= |r1sat_n;
      s2_side.deg0  <= b2.den <= DW'(thr_sq);
      s2_side.deg2a <= 1'b0;
      s2_side.deg2b <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        s2_side.r1[i] <= r1_n[i];
        s2_n0mag[i]   <= n0mag_n[i];
      end
      s2_den <= b2.den;
      s2_cc  <= CCW'(pb_cc[0]) + CCW'(pb_cc[1]) + CCW'(pb_cc[2]);
    end
  end

  // Divide numerators by the squared length
  for (genvar i = 0; i < 3; i++) begin : g_div
    vr3_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
      .clk(clk), .en(en), .num(s2_n0mag[i]), .den(s2_den), .quo(quo[i])
    );
  end

  // Length of the plane mirror axis, squared
  vr3_mul #(.AW(DW), .BW(CCW)) u_dencc (
    .clk(clk), .en(en), .a(s2_den), .b(s2_cc), .p(dencc)
  );

  // Side line: carry word info alongside the divider
  always_comb begin
    sd0       = s2_side;
    sd0.deg2a = TH2W'(s2_cc) <= (TH2W'(thr_sq) << (2 * F));
    sd_fix       = sd[2];
    sd_fix.deg2b = TH4W'(dencc) <= (TH4W'(thr_sq) << (4 * F));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= sd0;
      for (int j = 2; j <= DL; j++) begin
        sd[j] <= (j == 3) ? sd_fix : sd[j-1];
      end
    end
  end

  // Final selection per mode
  for (genvar i = 0; i < 3; i++) begin : g_fin
    assign clp0[i] = clip_fn(MXW'(quo[i]), sd[DL].nneg[i]);
    assign clp2[i] = clip_fn(MXW'(quo[i]), !sd[DL].nneg[i]);
    assign clpv[i] = clip_fn(MXW'(mag_fn(sd[DL].v[i])), !sd[DL].v[i][W-1]);
  end

  always_comb begin
    fin_deg = 1'b0;
    fin_sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fin_val[i] = sd[DL].v[i];
    end
    case (sd[DL].mode)
      vr3_pkg::MODE_VECTOR: begin
        if (sd[DL].deg0) begin
          fin_deg = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            fin_val[i] = clp0[i][W-1:0];
            fin_sat    = fin_sat | clp0[i][W];
          end
        end
      end
      vr3_pkg::MODE_AXIS: begin
        for (int i = 0; i < 3; i++) begin
          fin_val[i] = sd[DL].r1[i];
        end
        fin_sat = sd[DL].sat1;
      end
      vr3_pkg::MODE_PLANE: begin
        if (sd[DL].deg2a) begin
          fin_deg = 1'b1;
          for (int i = 0; i < 3; i++) begin
            fin_val[i] = clpv[i][W-1:0];
            fin_sat    = fin_sat | clpv[i][W];
          end
        end else if (sd[DL].deg2b) begin
          fin_deg = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            fin_val[i] = clp2[i][W-1:0];
            fin_sat    = fin_sat | clp2[i][W];
          end
        end
      end
      default: begin
        fin_deg = 1'b0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_x      <= fin_val[0];
      out_y      <= fin_val[1];
      out_z      <= fin_val[2];
      degenerate <= fin_deg;
      saturated  <= fin_sat;
    end
  end

endmodule

### hdl/vr3_check.sv
module vr3_check #(
  parameter int W = 32
) (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W-1:0] out_x,
  input logic signed [W-1:0] out_y,
  input logic signed [W-1:0] out_z,
  input logic                degenerate,
  input logic                saturated
);

  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Hold a waiting word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_x, out_y, out_z, degenerate, saturated}))
    else $error("output word changed while stalled");

  // Stalled output blocks intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Saturation flag only with a clipped coordinate
  a_sat_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == CMAX || out_x == CMIN || out_y == CMAX || out_y == CMIN ||
       out_z == CMAX || out_z == CMIN))
    else $error("saturated without a clipped coordinate");

endmodule

bind vector_reflection_3d vr3_check #(.W(COORD_WIDTH)) u_vr3_check (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_x(out_x),
  .out_y(out_y),
  .out_z(out_z),
  .degenerate(degenerate),
  .saturated(saturated)
);
